FILE: sv/ebml_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EBML decoder package
// Types, status codes and small helper functions shared by the EBML
// variable-length integer and element ID decoder.
// ----------------------------------------------------------------------------
package ebml_pkg;

  localparam int unsigned ValueW   = 56;
  localparam int unsigned WidthW   = 4;
  localparam int unsigned LimitW   = 4;
  localparam int unsigned LeftW    = 3;
  localparam logic [LimitW-1:0] IdLimitFloor = 4'd4;
  localparam logic [LimitW-1:0] IdLimitReset = 4'd4;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VINT    = 3'd1,
    ST_ID_TOO_LONG = 3'd2,
    ST_ID_ZERO     = 3'd3,
    ST_ID_ALL_ONES = 3'd4,
    ST_ID_NOT_MIN  = 3'd5
  } status_t;

  // Operation selected on the first byte of a number
  typedef enum logic {
    OP_VINT = 1'b0,
    OP_ID   = 1'b1
  } op_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       op;
  } in_item_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [WidthW-1:0] width;
    status_t           status;
  } out_item_t;

  // Encoded width from the position of the leading one (1..8)
  function automatic logic [WidthW-1:0] lead_one_width(input logic [7:0] b);
    logic [WidthW-1:0] w;
    w = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) w = 4'(8 - i);
    end
    return w;
  endfunction

  // All-ones pattern of a width-w number: 7*w value bits
  function automatic logic [ValueW-1:0] ones_for_width(input logic [WidthW-1:0] w);
    logic [ValueW:0] t;
    t = (57'd1 << (7 * w)) - 57'd1;
    return t[ValueW-1:0];
  endfunction

endpackage

FILE: sv/ebml_vint_and_id_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EBML vint and element ID decoder
// Decodes EBML variable-length integers and element IDs from a byte stream.
// ----------------------------------------------------------------------------
// The block takes one byte per transaction and accepts a new byte every cycle
// as long as the result register is empty or being drained. The first byte of
// a number sets its width (1 to 8 bytes, from the leading one) and, via op,
// plain vint or element ID mode; a zero first byte yields an immediate result
// with status bad vint. The result for a number appears in the result register
// in the cycle after its last byte is taken; the value has the length marker
// cleared. In ID mode the status reports, in order of priority, an ID wider
// than max(cfg limit, 4), a zero ID, an all-ones ID or a non-minimal
// encoding. The ID width limit (cfg_wr_en/cfg_wr_data, resets to 4) must be
// written only while the block is idle; the block does not enforce this.
module ebml_vint_and_id_decoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ebml_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ebml_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data
);
  import ebml_pkg::*;

  // Decode state
  logic [LeftW-1:0]  bytes_left_r, bytes_left_nxt;
  logic [WidthW-1:0] total_width_r, total_width_nxt;
  logic [ValueW-1:0] acc_r, acc_nxt;
  logic              id_mode_r, id_mode_nxt;
  logic [LimitW-1:0] max_id_len_r;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              in_fire;
  logic              first_byte;
  logic [WidthW-1:0] w_first;
  logic [7:0]        marker;
  logic              emit;
  logic [WidthW-1:0] w_emit;
  logic              id_emit;
  logic [LimitW-1:0] id_limit;
  logic [ValueW-1:0] ones_w;
  logic [ValueW-1:0] ones_prev;
  status_t           st_emit;

  // Take a byte whenever the result register can be refilled
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign first_byte = (bytes_left_r == '0);
  assign w_first    = lead_one_width(in_data.data_byte);
  assign marker     = 8'(8'h80 >> (w_first - 4'd1));

  // Next decode state and completion
  always_comb begin
    bytes_left_nxt  = bytes_left_r;
    total_width_nxt = total_width_r;
    acc_nxt         = acc_r;
    id_mode_nxt     = id_mode_r;
    emit            = 1'b0;
    if (first_byte) begin
      if (in_data.data_byte != 8'd0) begin
        total_width_nxt = w_first;
        id_mode_nxt     = in_data.op;
        acc_nxt         = {48'd0, in_data.data_byte & ~marker};
        bytes_left_nxt  = LeftW'(w_first - 4'd1);
        emit            = (w_first == 4'd1);
      end
    end else begin
      acc_nxt        = {acc_r[ValueW-9:0], in_data.data_byte};
      bytes_left_nxt = bytes_left_r - 3'd1;
      emit           = (bytes_left_r == 3'd1);
    end
  end

  // ID checks on the finished number
  assign w_emit    = first_byte ? w_first : total_width_r;
  assign id_emit   = first_byte ? (in_data.op == OP_ID) : id_mode_r;
  assign id_limit  = (max_id_len_r > IdLimitFloor) ? max_id_len_r : IdLimitFloor;
  assign ones_w    = ones_for_width(w_emit);
  assign ones_prev = ones_for_width(w_emit - 4'd1);

  always_comb begin
    st_emit = ST_OK;
    if (id_emit) begin
      if (w_emit > id_limit) begin
        st_emit = ST_ID_TOO_LONG;
      end else if (acc_nxt == '0) begin
        st_emit = ST_ID_ZERO;
      end else if (acc_nxt == ones_w) begin
        st_emit = ST_ID_ALL_ONES;
      end else if (w_emit != 4'd1 && acc_nxt < ones_prev) begin
        st_emit = ST_ID_NOT_MIN;
      end
    end
  end

  // Load, hold or drain the result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && first_byte && in_data.data_byte == 8'd0) begin
      out_valid_nxt       = 1'b1;
      out_data_nxt.value  = '0;
      out_data_nxt.width  = '0;
      out_data_nxt.status = ST_BAD_VINT;
    end else if (in_fire && emit) begin
      out_valid_nxt       = 1'b1;
      out_data_nxt.value  = acc_nxt;
      out_data_nxt.width  = w_emit;
      out_data_nxt.status = st_emit;
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r  <= '0;
      total_width_r <= '0;
      acc_r         <= '0;
      id_mode_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      max_id_len_r  <= IdLimitReset;
    end else begin
      if (in_fire) begin
        bytes_left_r  <= bytes_left_nxt;
        total_width_r <= total_width_nxt;
        acc_r         <= acc_nxt;
        id_mode_r     <= id_mode_nxt;
      end
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_id_len_r <= cfg_wr_data;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Assertions
  a_bad_vint_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == ST_BAD_VINT |->
      out_data_r.width == '0 && out_data_r.value == '0)
    else $error("bad vint result carries nonzero value or width");

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != ST_BAD_VINT |->
      out_data_r.width >= 4'd1 && out_data_r.width <= 4'd8)
    else $error("result width out of range");

  a_left_below_width: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r != '0 |-> {1'b0, bytes_left_r} < total_width_r)
    else $error("continuation count exceeds number width");

  a_width_one_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.width == 4'd1 |-> out_data_r.value[ValueW-1:7] == '0)
    else $error("one-byte number wider than seven bits");

endmodule

FILE: bench/ebml_vint_and_id_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EBML vint and element ID decoder testbench
// Streams directed and random EBML numbers (plain vints and element IDs,
// well-formed and misaligned) into the decoder under several ID width limits.
// A byte-level decoder model in a small scoreboard class predicts every
// number, and each result is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module ebml_vint_and_id_decoder_unit_tb;
  import ebml_pkg::*;

  localparam int StallLimit  = 3000;
  localparam int HoldCycles  = 200;
  localparam int SettleTime  = 4;
  localparam int PhaseCount  = 8;
  localparam int PhaseBytes  = 104;
  localparam int HoldPhase   = 6;
  localparam int PausePhase  = 3;

  // Byte-level decoder model and store of numbers still owed by the block
  class vint_scoreboard;
    logic [3:0]  id_limit;
    logic [2:0]  bytes_left;
    logic [3:0]  total_width;
    logic [55:0] acc;
    op_t         id_mode;
    out_item_t   pending_numbers[$];
    int          errors;
    int          n_bytes;
    int          n_numbers;
    int          status_hits[6];

    function new();
      id_limit    = IdLimitReset;
      bytes_left  = '0;
      total_width = '0;
      acc         = '0;
      id_mode     = OP_VINT;
    endfunction

    static function logic [63:0] all_ones(int w);
      return (64'd1 << (7 * w)) - 64'd1;
    endfunction

    function void set_limit(logic [3:0] v);
      id_limit = v;
    endfunction

    // Close the number in progress and queue its expected result
    function void finish_number();
      out_item_t   want;
      logic [3:0]  lim;
      logic [63:0] v64;
      status_t     st;
      st  = ST_OK;
      v64 = {8'h00, acc};
      if (id_mode == OP_ID) begin
        lim = (id_limit > IdLimitFloor) ? id_limit : IdLimitFloor;
        if (total_width > lim) st = ST_ID_TOO_LONG;
        else if (acc == '0) st = ST_ID_ZERO;
        else if (v64 == all_ones(total_width)) st = ST_ID_ALL_ONES;
        else if (total_width != 4'd1 && v64 < all_ones(total_width - 1))
          st = ST_ID_NOT_MIN;
      end
      want.value  = acc;
      want.width  = total_width;
      want.status = st;
      pending_numbers.push_back(want);
    endfunction

    // Advance the model by one accepted byte
    function void note_byte(in_item_t it);
      logic [7:0] b;
      int         w;
      out_item_t  bad;
      b = it.data_byte;
      n_bytes++;
      if (bytes_left == 0) begin
        if (b == 8'h00) begin
          bad.value  = '0;
          bad.width  = '0;
          bad.status = ST_BAD_VINT;
          pending_numbers.push_back(bad);
          return;
        end
        w = 1;
        while (!b[8 - w]) w++;
        id_mode     = op_t'(it.op);
        total_width = 4'(w);
        acc         = {48'h0, b & (8'hFF >> w)};
        if (w == 1) finish_number();
        else bytes_left = 3'(w - 1);
      end else begin
        acc        = {acc[47:0], b};
        bytes_left = bytes_left - 3'd1;
        if (bytes_left == 0) finish_number();
      end
    endfunction

    // Compare one result with the oldest expected number
    function void check_number(out_item_t got);
      out_item_t want;
      if (pending_numbers.size() == 0) begin
        $error("unexpected result: value %0h width %0d status %0d",
               got.value, got.width, got.status);
        errors++;
        return;
      end
      want = pending_numbers.pop_front();
      n_numbers++;
      status_hits[int'(want.status)]++;
      if (got.value !== want.value) begin
        $error("value: expected %0h, actual %0h", want.value, got.value);
        errors++;
      end
      if (got.width !== want.width) begin
        $error("width: expected %0d, actual %0d", want.width, got.width);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_wr_en;
  logic [3:0] cfg_wr_data;

  vint_scoreboard sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int stream_left;
  int limits_used;
  int quiet_cycles;

  wire in_fire  = in_valid && in_ready;
  wire out_fire = out_valid && out_ready;

  ebml_vint_and_id_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Note accepted bytes, then check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_fire) sb.note_byte(in_data);
      if (out_fire) sb.check_number(out_data);
    end
  end

  // Drop the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one byte, with random idle cycles first; return once accepted
  task automatic send_byte(input logic [7:0] b, input op_t o);
    in_item_t it;
    int       w;
    it.data_byte = b;
    it.op        = o;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // track number boundaries so phases can end on a complete number
    if (stream_left == 0) begin
      if (b != 8'h00) begin
        w = 1;
        while (!b[8 - w]) w++;
        stream_left = w - 1;
      end
    end else begin
      stream_left--;
    end
  endtask

  // Encode a value at the given width; op is random on continuation bytes
  task automatic send_number(input op_t o, input int w, input logic [55:0] v);
    logic [63:0] enc;
    enc = ({8'h00, v} & vint_scoreboard::all_ones(w)) | (64'd1 << (7 * w));
    for (int i = w - 1; i >= 0; i--) begin
      send_byte(enc[8*i +: 8], (i == w - 1) ? o : op_t'($urandom_range(1)));
    end
  endtask

  // Pick a value that lands on the ID checks often
  function automatic logic [55:0] pick_value(int w);
    logic [63:0] ones;
    logic [63:0] shorter;
    logic [63:0] r;
    ones    = vint_scoreboard::all_ones(w);
    shorter = vint_scoreboard::all_ones(w - 1);
    r       = {$urandom, $urandom};
    case ($urandom_range(7))
      0:       r = '0;
      1:       r = ones;
      2:       r = shorter;
      3:       r = shorter + 64'd1;
      4:       r = r & shorter;
      5:       r = ones - 64'd1;
      default: r = r & ones;
    endcase
    return r[55:0];
  endfunction

  // Drop valid and hold until every expected number has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_numbers.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [3:0] v);
    drain();
    repeat (SettleTime) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_limit(v);
    limits_used++;
  endtask

  initial begin
    logic [3:0] lim;
    int         sent_at_start;
    int         k;
    int         w;
    bit         held;
    bit         paused;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    hold_req      = 1'b0;
    stream_left   = 0;
    limits_used   = 1;
    send_idle_pct = 31;
    recv_idle_pct = 65;
    held          = 1'b0;
    paused        = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cases under the reset ID limit
    send_byte(8'h00, OP_VINT);
    send_byte(8'h00, OP_ID);
    send_number(OP_VINT, 1, 56'h7F);
    send_number(OP_ID, 1, 56'h00);
    send_number(OP_ID, 1, 56'h7F);
    send_number(OP_ID, 1, 56'h01);
    send_number(OP_ID, 2, 56'h7F);
    send_number(OP_ID, 2, 56'h05);
    send_number(OP_ID, 5, 56'h1234);
    send_number(OP_VINT, 8, {56{1'b1}});
    drain();

    // Random phases, one ID limit each
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0:       lim = 4'd1;
        1:       lim = 4'd8;
        2:       lim = 4'd15;
        3:       lim = 4'd0;
        4:       lim = 4'd5;
        5:       lim = 4'd6;
        6:       lim = 4'd7;
        default: lim = 4'd4;
      endcase
      write_limit(lim);
      if (p < 3) begin
        send_idle_pct = 31;
        recv_idle_pct = 65;
      end else if (p < 6) begin
        send_idle_pct = 65;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      sent_at_start = sb.n_bytes;
      while (sb.n_bytes - sent_at_start < PhaseBytes) begin
        // stall the result side while bytes keep coming
        if (p == HoldPhase && !held && sb.n_bytes - sent_at_start > PhaseBytes / 2) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
        // let the block run dry once between numbers
        if (p == PausePhase && !paused && stream_left == 0 &&
            sb.n_bytes - sent_at_start > PhaseBytes / 2) begin
          drain();
          paused = 1'b1;
        end
        k = $urandom_range(99);
        if (k < 8) begin
          send_byte(8'($urandom), op_t'($urandom_range(1)));
        end else if (k < 12) begin
          send_byte(8'h00, op_t'($urandom_range(1)));
        end else begin
          w = $urandom_range(1, 8);
          send_number(op_t'($urandom_range(1)), w, pick_value(w));
        end
      end
      // complete any number left open by misaligned bytes
      while (stream_left != 0) send_byte(8'($urandom), op_t'($urandom_range(1)));
    end

    drain();
    repeat (10) @(posedge clk);

    $display("Covered %0d bytes and %0d results over %0d ID limit settings",
             sb.n_bytes, sb.n_numbers, limits_used);
    $display("Statuses: ok %0d, bad vint %0d, too long %0d, zero %0d, all ones %0d, not minimal %0d",
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
             sb.status_hits[3], sb.status_hits[4], sb.status_hits[5]);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
